@@ src/fwtt_pkg.sv @@
// Shared types and constants for the feedback window threshold tuner.
`default_nettype none
package fwtt_pkg;

  localparam int RATE_W      = 17;
  localparam int THR_W       = 21;
  localparam int THR_EXT_W   = 22;
  localparam int DIV_STEPS   = 17;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int PCT_DIV     = 100;
  localparam int RATE_HI_MUL = 20;
  localparam int RATE_LO_MUL = 100;

  localparam logic [THR_W-1:0]   THR_MIN   = 21'd131072;
  localparam logic [THR_W-1:0]   THR_MAX   = 21'd1310720;
  localparam logic [THR_W-1:0]   THR_RESET = 21'd327680;
  localparam logic [RECIP_W-1:0] RECIP     = 18'd167772;

  localparam logic [1:0] ACT_OBSERVE = 2'd0;
  localparam logic [1:0] ACT_TUNE    = 2'd1;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [1:0] entry;
  } win_ctrl_t;

endpackage
`default_nettype wire

@@ src/feedback_window_threshold_tuner_core.sv @@
// Top level of the feedback window threshold tuner with its item sequencer.
// An observe word reads and then writes the window before the rates; a tune word with enough
// fill may scale the threshold up to twice and then clamp it; an empty window gives zero rates.
// A new word is taken only when the sequencer is idle; the shared 17-step divider computes the
// three rates in turn, and a result that is not taken stalls the sequencer in its last state.
// Synchronous active-low reset empties the window and loads threshold 5.0.
`default_nettype none
module feedback_window_threshold_tuner_core
  import fwtt_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int MIN_FILL     = 100,
  localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic              in_true_rogue,
  input  wire logic              in_pred_anomaly,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [THR_W-1:0]       out_threshold,
  output logic [RATE_W-1:0]      out_anomaly_rate,
  output logic [RATE_W-1:0]      out_false_positive_rate,
  output logic [RATE_W-1:0]      out_false_negative_rate,
  output logic [CNT_W-1:0]       out_window_fill,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [THR_W-1:0]  cfg_initial_threshold
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CMP_W = CNT_W + 7;

  typedef enum logic [3:0] {
    S_IDLE, S_OBS_RD, S_OBS_WR, S_FP, S_FP_WAIT, S_FN, S_FN_WAIT,
    S_CLAMP, S_RATE, S_RATE_WAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {SEL_ANOM, SEL_FP, SEL_FN} rate_sel_t;

  state_t               state_r;
  rate_sel_t            sel_r;
  logic [1:0]           act_r;
  logic [1:0]           entry_r;
  logic [THR_W-1:0]     live_r;
  logic [THR_EXT_W-1:0] tw_r;
  logic [RATE_W-1:0]    an_rate_r;
  logic [RATE_W-1:0]    fp_rate_r;
  logic [RATE_W-1:0]    fn_rate_r;
  logic                 out_valid_r;
  logic [THR_W-1:0]     out_thr_r;
  logic [RATE_W-1:0]    out_an_r;
  logic [RATE_W-1:0]    out_fp_r;
  logic [RATE_W-1:0]    out_fn_r;
  logic [CNT_W-1:0]     out_fill_r;

  win_ctrl_t            win_ctrl;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     fp_cnt;
  logic [CNT_W-1:0]     fn_cnt;
  logic [CNT_W-1:0]     an_cnt;
  logic                 in_acc;
  logic                 fp_hi;
  logic                 fp_lo;
  logic                 fn_hi;
  logic                 fn_lo;
  logic                 scale_start;
  logic                 scale_up;
  logic                 scale_done;
  logic [THR_EXT_W-1:0] scale_t;
  logic                 div_start;
  logic                 div_done;
  logic [CNT_W-1:0]     div_count;
  logic [RATE_W-1:0]    div_quo;
  logic [THR_W-1:0]     clamped;
  logic                 out_free;

  assign in_ready  = state_r == S_IDLE && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = state_r == S_IDLE;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    fp_hi = CMP_W'(fp_cnt) * CMP_W'(RATE_HI_MUL) > CMP_W'(fill);
    fp_lo = CMP_W'(fp_cnt) * CMP_W'(RATE_LO_MUL) < CMP_W'(fill);
    fn_hi = CMP_W'(fn_cnt) * CMP_W'(RATE_HI_MUL) > CMP_W'(fill);
    fn_lo = CMP_W'(fn_cnt) * CMP_W'(RATE_LO_MUL) < CMP_W'(fill);

    win_ctrl.rd    = state_r == S_OBS_RD;
    win_ctrl.wr    = state_r == S_OBS_WR;
    win_ctrl.entry = entry_r;

    scale_start = (state_r == S_FP && (fp_hi || fp_lo)) ||
                  (state_r == S_FN && (fn_hi || fn_lo));
    scale_up    = (state_r == S_FP) ? fp_hi : fn_lo;

    div_start = state_r == S_RATE && fill != '0;
    unique case (sel_r)
      SEL_ANOM: div_count = an_cnt;
      SEL_FP:   div_count = fp_cnt;
      SEL_FN:   div_count = fn_cnt;
      default:  div_count = an_cnt;
    endcase

    if (tw_r < THR_EXT_W'(THR_MIN)) begin
      clamped = THR_MIN;
    end else if (tw_r > THR_EXT_W'(THR_MAX)) begin
      clamped = THR_MAX;
    end else begin
      clamped = tw_r[THR_W-1:0];
    end
  end

  fwtt_win #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PTR_W        (PTR_W),
    .CNT_W        (CNT_W)
  ) u_win (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (win_ctrl),
    .fill   (fill),
    .fp_cnt (fp_cnt),
    .fn_cnt (fn_cnt),
    .an_cnt (an_cnt)
  );

  fwtt_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scale_start),
    .up    (scale_up),
    .t_in  (tw_r),
    .done  (scale_done),
    .t_out (scale_t)
  );

  fwtt_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_count),
    .divisor  (fill),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_ANOM;
      live_r      <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        live_r <= cfg_initial_threshold;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            act_r   <= in_action;
            entry_r <= {in_pred_anomaly, in_true_rogue};
            tw_r    <= THR_EXT_W'(live_r);
            sel_r   <= SEL_ANOM;
            if (in_action == ACT_OBSERVE) begin
              state_r <= S_OBS_RD;
            end else if (in_action == ACT_TUNE && fill >= CNT_W'(MIN_FILL)) begin
              state_r <= S_FP;
            end else begin
              state_r <= S_RATE;
            end
          end
        end
        S_OBS_RD: state_r <= S_OBS_WR;
        S_OBS_WR: state_r <= S_RATE;
        S_FP: state_r <= scale_start ? S_FP_WAIT : S_FN;
        S_FP_WAIT: begin
          if (scale_done) begin
            tw_r    <= scale_t;
            state_r <= S_FN;
          end
        end
        S_FN: state_r <= scale_start ? S_FN_WAIT : S_CLAMP;
        S_FN_WAIT: begin
          if (scale_done) begin
            tw_r    <= scale_t;
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          live_r  <= clamped;
          state_r <= S_RATE;
        end
        S_RATE: begin
          if (fill == '0) begin
            an_rate_r <= '0;
            fp_rate_r <= '0;
            fn_rate_r <= '0;
            state_r   <= S_DONE;
          end else begin
            state_r <= S_RATE_WAIT;
          end
        end
        S_RATE_WAIT: begin
          if (div_done) begin
            unique case (sel_r)
              SEL_ANOM: begin
                an_rate_r <= div_quo;
                sel_r     <= SEL_FP;
                state_r   <= S_RATE;
              end
              SEL_FP: begin
                fp_rate_r <= div_quo;
                sel_r     <= SEL_FN;
                state_r   <= S_RATE;
              end
              default: begin
                fn_rate_r <= div_quo;
                state_r   <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_thr_r   <= live_r;
            out_an_r    <= an_rate_r;
            out_fp_r    <= fp_rate_r;
            out_fn_r    <= fn_rate_r;
            out_fill_r  <= fill;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_threshold           = out_thr_r;
  assign out_anomaly_rate        = out_an_r;
  assign out_false_positive_rate = out_fp_r;
  assign out_false_negative_rate = out_fn_r;
  assign out_window_fill         = out_fill_r;

  // The two error classes are disjoint, so together they never exceed the fill.
  a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(fp_cnt) + (CNT_W + 1)'(fn_cnt) <= (CNT_W + 1)'(fill))
    else $error("error counts exceed window fill");

  a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLAMP |=> live_r >= THR_MIN && live_r <= THR_MAX)
    else $error("threshold outside clamp range after update");

  a_rates_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_an_r <= RATE_W'(65536) && out_fp_r <= RATE_W'(65536) &&
                    out_fn_r <= RATE_W'(65536))
    else $error("rate above one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after an accepted word");

  a_acc_act_latched: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action == ACT_OBSERVE |=> state_r == S_OBS_RD && act_r == ACT_OBSERVE)
    else $error("observe word did not start a window read");

endmodule
`default_nettype wire

@@ src/fwtt_div.sv @@
// Shared restoring divider producing a Q1.16 ratio of a count to the window fill.
`default_nettype none
module fwtt_div
  import fwtt_pkg::*;
#(
  parameter int CNT_W = 11
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [CNT_W-1:0]  dividend,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [RATE_W-1:0]      quotient
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic [CNT_W:0]    rem_r;
  logic [RATE_W-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic              last;

  always_comb begin
    trial = (step_r == '0) ? rem_r : {rem_r[CNT_W-1:0], 1'b0};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
    last  = busy_r && step_r == STEP_W'(DIV_STEPS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend};
      step_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff : trial;
      quo_r  <= {quo_r[RATE_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ src/fwtt_scale.sv @@
// Threshold scaler applying a one percent step up or down with truncation.
`default_nettype none
module fwtt_scale
  import fwtt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 up,
  input  wire logic [THR_EXT_W-1:0] t_in,
  output logic                      done,
  output logic [THR_EXT_W-1:0]      t_out
);

  localparam int PROD_W = THR_EXT_W + RECIP_W;
  localparam int Q_W    = PROD_W - RECIP_SHIFT;
  localparam int R_W    = THR_EXT_W + 1;

  logic [PROD_W-1:0]    prod_r;
  logic [THR_EXT_W-1:0] t_r;
  logic                 up_r;
  logic                 busy_r;
  logic                 done_r;
  logic [THR_EXT_W-1:0] t_out_r;
  logic [Q_W-1:0]       q0;
  logic [R_W-1:0]       rem_full;
  logic [7:0]           rem;
  logic                 adj;
  logic [7:0]           rem_fix;
  logic [THR_EXT_W-1:0] q;
  logic [THR_EXT_W-1:0] t_nxt;

  always_comb begin
    q0       = prod_r[PROD_W-1:RECIP_SHIFT];
    rem_full = {1'b0, t_r} - (R_W'(q0) * R_W'(PCT_DIV));
    rem      = rem_full[7:0];
    adj      = rem >= 8'(PCT_DIV);
    rem_fix  = adj ? rem - 8'(PCT_DIV) : rem;
    q        = THR_EXT_W'(q0) + THR_EXT_W'(adj);
    t_nxt    = up_r ? t_r + q : t_r - q - THR_EXT_W'(rem_fix != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      t_r    <= t_in;
      up_r   <= up;
      prod_r <= PROD_W'(t_in) * PROD_W'(RECIP);
    end
    if (busy_r) begin
      t_out_r <= t_nxt;
    end
  end

  assign done  = done_r;
  assign t_out = t_out_r;

endmodule
`default_nettype wire

@@ src/fwtt_win.sv @@
// Feedback window store with write pointer, fill level and running error and anomaly counts.
`default_nettype none
module fwtt_win
  import fwtt_pkg::*;
#(
  parameter int WINDOW_DEPTH = 1024,
  parameter int PTR_W        = 10,
  parameter int CNT_W        = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire win_ctrl_t        ctrl,
  output logic [CNT_W-1:0]      fill,
  output logic [CNT_W-1:0]      fp_cnt,
  output logic [CNT_W-1:0]      fn_cnt,
  output logic [CNT_W-1:0]      an_cnt
);

  logic [1:0]       mem [WINDOW_DEPTH];
  logic [1:0]       rd_data_r;
  logic [PTR_W-1:0] ptr_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fp_r;
  logic [CNT_W-1:0] fn_r;
  logic [CNT_W-1:0] an_r;
  logic             full;
  logic [1:0]       old;
  logic [CNT_W-1:0] fp_nxt;
  logic [CNT_W-1:0] fn_nxt;
  logic [CNT_W-1:0] an_nxt;

  always_comb begin
    full   = fill_r == CNT_W'(WINDOW_DEPTH);
    old    = full ? rd_data_r : 2'b00;
    fp_nxt = fp_r + CNT_W'(!ctrl.entry[0] && ctrl.entry[1]) - CNT_W'(!old[0] && old[1]);
    fn_nxt = fn_r + CNT_W'(ctrl.entry[0] && !ctrl.entry[1]) - CNT_W'(old[0] && !old[1]);
    an_nxt = an_r + CNT_W'(ctrl.entry[1]) - CNT_W'(old[1]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_data_r <= mem[ptr_r];
    end
    if (ctrl.wr) begin
      mem[ptr_r] <= ctrl.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      fill_r <= '0;
      fp_r   <= '0;
      fn_r   <= '0;
      an_r   <= '0;
    end else if (ctrl.wr) begin
      ptr_r  <= (ptr_r == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
      fill_r <= full ? fill_r : fill_r + CNT_W'(1);
      fp_r   <= fp_nxt;
      fn_r   <= fn_nxt;
      an_r   <= an_nxt;
    end
  end

  assign fill   = fill_r;
  assign fp_cnt = fp_r;
  assign fn_cnt = fn_r;
  assign an_cnt = an_r;

endmodule
`default_nettype wire
